// ===== hw/rtl/tlfp_pkg.sv =====
// Package for the telemetry line field parser.
// Holds the character codes, status codes, parse modes and result item types.
// No dependencies.
`timescale 1ns / 1ps

package tlfp_pkg;

	// Field layout of one line.
	localparam int unsigned OPTIONAL_FIELDS = 65;
	localparam int unsigned FIELD_W = 7;
	localparam logic [FIELD_W-1:0] LAST_REQ_FIELD = FIELD_W'(3);
	localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(3 + OPTIONAL_FIELDS);

	// Decimal magnitude limit.
	localparam int unsigned MAG_W = 31;
	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	// Character codes.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_R      = 8'h52;

	// Line status codes.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_SENTINEL = 3'd1;
	localparam logic [2:0] ST_BAD_GEAR    = 3'd2;
	localparam logic [2:0] ST_BAD_REQ     = 3'd3;
	localparam logic [2:0] ST_BAD_OPT     = 3'd4;

	// Parse modes.
	typedef enum logic [2:0] {
		MODE_HUNT,
		MODE_GEAR,
		MODE_GSEP,
		MODE_REQ,
		MODE_OSTART,
		MODE_ONUM,
		MODE_TRAIL,
		MODE_DRAIN
	} mode_t;

	// One result item.
	typedef struct packed {
		logic [FIELD_W-1:0] index;
		logic signed [31:0] value;
		logic               is_status;
		logic [2:0]         status;
		logic               last;
	} res_t;

	// Up to two result items produced by one line byte.
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} res_pair_t;

endpackage

// ===== hw/rtl/tlfp_parser.sv =====
// Parse state machine of the telemetry line field parser.
// Consumes one registered line byte per step and yields up to two result items.
// Depends on tlfp_pkg.
`timescale 1ns / 1ps

module tlfp_parser import tlfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] char_in,
	output res_pair_t  res
);

	mode_t                mode_q, mode_nxt;
	logic [FIELD_W-1:0]   fnum_q, fnum_nxt;
	logic [MAG_W-1:0]     mag_q, mag_nxt;
	logic                 neg_q, neg_nxt;
	logic                 dseen_q, dseen_nxt;
	logic [2:0]           ferr_q, ferr_nxt;

	logic                 is_dig;
	logic                 is_trl;
	logic                 is_gear;
	logic [MAG_W+3:0]     acc_wide;
	logic [MAG_W-1:0]     acc_mag;
	logic                 fld_v;
	logic signed [31:0]   fld_val;
	logic [2:0]           sts_code;
	res_t                 fld_item;
	res_t                 sts_item;

	// Character classes.
	assign is_dig = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign is_trl = (char_in == CH_SEMI) || (char_in == CH_CR) || (char_in == CH_LF) ||
			(char_in == CH_SPACE) || (char_in == CH_TAB);
	assign is_gear = (char_in == CH_R) || (char_in == CH_N) ||
			((char_in >= CH_ONE) && (char_in <= CH_NINE));

	// Times-ten accumulate with saturation.
	assign acc_wide = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) +
			(MAG_W+4)'(char_in - CH_ZERO);
	assign acc_mag = (acc_wide > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX : acc_wide[MAG_W-1:0];

	// Result items of this byte. A zero byte always closes the line.
	always_comb begin
		fld_v = 1'b0;
		fld_val = neg_q ? (32'sd0 - $signed({1'b0, mag_q})) : $signed({1'b0, mag_q});
		sts_code = ST_OK;
		case (mode_q)
			MODE_HUNT: begin
				sts_code = ST_NO_SENTINEL;
			end
			MODE_GEAR: begin
				sts_code = ST_BAD_GEAR;
				if (char_in == CH_MINUS) begin
					fld_v = 1'b1;
					fld_val = $signed({24'b0, CH_R});
				end else if (char_in == CH_ZERO) begin
					fld_v = 1'b1;
					fld_val = $signed({24'b0, CH_N});
				end else if (is_gear) begin
					fld_v = 1'b1;
					fld_val = $signed({24'b0, char_in});
				end
			end
			MODE_GSEP: begin
				sts_code = ST_BAD_REQ;
			end
			MODE_REQ: begin
				fld_v = !is_dig && dseen_q;
				sts_code = (!dseen_q || (fnum_q < LAST_REQ_FIELD)) ? ST_BAD_REQ : ST_OK;
			end
			MODE_ONUM: begin
				fld_v = !is_dig && dseen_q;
				sts_code = dseen_q ? ST_OK : ST_BAD_OPT;
			end
			MODE_DRAIN: begin
				sts_code = ferr_q;
			end
			default: begin
				sts_code = ST_OK;
			end
		endcase
	end

	// Pack the items; the status item follows a field item of the same byte.
	always_comb begin
		fld_item = '0;
		fld_item.index = fnum_q;
		fld_item.value = fld_val;
		sts_item = '0;
		sts_item.is_status = 1'b1;
		sts_item.status = sts_code;
		sts_item.last = 1'b1;
		res.v0 = step && (fld_v || (char_in == CH_NUL));
		res.v1 = step && fld_v && (char_in == CH_NUL);
		res.r0 = fld_v ? fld_item : sts_item;
		res.r1 = sts_item;
	end

	// Next parse state.
	always_comb begin
		mode_nxt = mode_q;
		fnum_nxt = fnum_q;
		mag_nxt = mag_q;
		neg_nxt = neg_q;
		dseen_nxt = dseen_q;
		ferr_nxt = ferr_q;
		if (char_in == CH_NUL) begin
			mode_nxt = MODE_HUNT;
			fnum_nxt = '0;
			mag_nxt = '0;
			neg_nxt = 1'b0;
			dseen_nxt = 1'b0;
			ferr_nxt = ST_OK;
		end else begin
			case (mode_q)
				MODE_HUNT: begin
					if (char_in == CH_DOLLAR) begin
						mode_nxt = MODE_GEAR;
					end
				end
				MODE_GEAR: begin
					if (char_in == CH_MINUS) begin
						neg_nxt = 1'b1;
						mode_nxt = MODE_GSEP;
					end else if ((char_in == CH_ZERO) || is_gear) begin
						mode_nxt = MODE_GSEP;
					end else begin
						ferr_nxt = ST_BAD_GEAR;
						mode_nxt = MODE_DRAIN;
					end
				end
				MODE_GSEP: begin
					if (neg_q && is_dig) begin
						mode_nxt = MODE_GSEP;
					end else if (char_in == CH_SEMI) begin
						mag_nxt = '0;
						neg_nxt = 1'b0;
						dseen_nxt = 1'b0;
						fnum_nxt = FIELD_W'(1);
						mode_nxt = MODE_REQ;
					end else begin
						ferr_nxt = ST_BAD_REQ;
						mode_nxt = MODE_DRAIN;
					end
				end
				MODE_REQ, MODE_OSTART, MODE_ONUM: begin
					if (is_dig) begin
						mag_nxt = acc_mag;
						dseen_nxt = 1'b1;
						if (mode_q == MODE_OSTART) begin
							mode_nxt = MODE_ONUM;
						end
					end else if ((mode_q == MODE_OSTART) &&
							((char_in == CH_MINUS) || (char_in == CH_PLUS))) begin
						neg_nxt = (char_in == CH_MINUS);
						mode_nxt = MODE_ONUM;
					end else if ((mode_q != MODE_OSTART) && !dseen_q) begin
						ferr_nxt = (mode_q == MODE_REQ) ? ST_BAD_REQ : ST_BAD_OPT;
						mode_nxt = MODE_DRAIN;
					end else if ((mode_q == MODE_REQ) && (fnum_q < LAST_REQ_FIELD)) begin
						// Speed and rpm must be followed by a separator.
						if (char_in == CH_SEMI) begin
							mag_nxt = '0;
							neg_nxt = 1'b0;
							dseen_nxt = 1'b0;
							fnum_nxt = fnum_q + FIELD_W'(1);
						end else begin
							ferr_nxt = ST_BAD_REQ;
							mode_nxt = MODE_DRAIN;
						end
					end else begin
						// Byte after a finished or empty value field.
						mag_nxt = '0;
						neg_nxt = 1'b0;
						dseen_nxt = 1'b0;
						if (char_in == CH_SEMI) begin
							if (fnum_q < LAST_FIELD) begin
								fnum_nxt = fnum_q + FIELD_W'(1);
								mode_nxt = MODE_OSTART;
							end else begin
								mode_nxt = MODE_TRAIL;
							end
						end else if (is_trl) begin
							mode_nxt = MODE_TRAIL;
						end else begin
							ferr_nxt = ST_BAD_OPT;
							mode_nxt = MODE_DRAIN;
						end
					end
				end
				MODE_TRAIL: begin
					if (!is_trl) begin
						ferr_nxt = ST_BAD_OPT;
						mode_nxt = MODE_DRAIN;
					end
				end
				default: begin
					mode_nxt = mode_q;
				end
			endcase
		end
	end

	// State registers advance once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HUNT;
			fnum_q <= '0;
			mag_q <= '0;
			neg_q <= 1'b0;
			dseen_q <= 1'b0;
			ferr_q <= ST_OK;
		end else if (step) begin
			mode_q <= mode_nxt;
			fnum_q <= fnum_nxt;
			mag_q <= mag_nxt;
			neg_q <= neg_nxt;
			dseen_q <= dseen_nxt;
			ferr_q <= ferr_nxt;
		end
	end

	// A second item is only ever the status item behind a field item.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		res.v1 |-> (res.v0 && !res.r0.is_status && res.r1.is_status))
		else $error("second result item is not a status item behind a field");

endmodule

// ===== hw/rtl/tlfp_res_queue.sv =====
// Four-entry result queue of the telemetry line field parser.
// Takes up to two result items per cycle and hands out one per cycle while pop is high.
// Depends on tlfp_pkg.
`timescale 1ns / 1ps

module tlfp_res_queue import tlfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  res_pair_t push,
	output logic      room,
	output logic      out_valid,
	input  logic      pop,
	output res_t      out_item
);

	res_t       mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;
	logic [2:0] count_nxt;

	// Room for two items, the most one byte can produce.
	assign room = (count_q <= 3'd2);
	assign out_valid = (count_q != 3'd0);
	assign out_item = mem_q[rd_q];
	assign count_nxt = count_q + 3'(push.v0) + 3'(push.v1) - 3'(pop && out_valid);

	// Storage writes.
	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_q + 2'd1] <= push.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + 2'(push.v0) + 2'(push.v1);
			if (pop && out_valid) begin
				rd_q <= rd_q + 2'd1;
			end
			count_q <= count_nxt;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overfilled");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.v0 || push.v1) |-> (count_q <= 3'd2))
		else $error("result items pushed without room");

	a_empty_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((count_q == 3'd0) && !push.v0 && !push.v1) |=> (count_q == 3'd0))
		else $error("result queue filled with no push");

endmodule

// ===== hw/rtl/telemetry_line_field_parser_core.sv =====
// Top level of the telemetry line field parser.
// Path: a byte's first result item is presented from the result queue once the byte has
// passed the input register and been pushed; a second item of the same byte follows it.
// Throughput: one byte per cycle. Input stalls only while the four-entry result queue
// holds more than two items, which happens only under result-side stalls.
// Reset: arst_n clears the input register's valid flag, parse state and queue pointers at once.
// Depends on tlfp_pkg, tlfp_parser and tlfp_res_queue.
`timescale 1ns / 1ps

module telemetry_line_field_parser_core import tlfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  logic [7:0]          char_byte,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [FIELD_W-1:0]  field_index,
	output logic signed [31:0]  field_value,
	output logic                is_status,
	output logic [2:0]          line_status,
	output logic                last_of_line
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       room;
	logic       step;
	logic       accept;
	res_pair_t  res;
	res_t       out_item;

	// The input register holds one byte until the queue can take its items.
	assign step = valid_s1 && room;
	assign char_stall = valid_s1 && !room;
	assign accept = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_byte;
		end
	end

	// Parse state machine.
	tlfp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.char_in (char_s1),
		.res     (res)
	);

	// Result queue.
	tlfp_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.room      (room),
		.out_valid (result_valid),
		.pop       (!result_stall),
		.out_item  (out_item)
	);

	// Result item fields.
	assign field_index = out_item.index;
	assign field_value = out_item.value;
	assign is_status = out_item.is_status;
	assign line_status = out_item.status;
	assign last_of_line = out_item.last;

endmodule
